### src/actk_pkg.sv
package actk_pkg;

	localparam int ROUND_KEYS = 11;
	localparam logic [3:0] LAST_ROUND = 4'(ROUND_KEYS - 1);

	localparam logic [1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [1:0] REG_KEY_HIGH = 2'd1;
	localparam logic [1:0] REG_DIR      = 2'd2;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_ECHO  = 2'd1;
	localparam logic [1:0] KIND_CHECK = 2'd2;

	localparam logic [1:0] POS_IDLE = 2'd0;
	localparam logic [1:0] POS_IV   = 2'd1;
	localparam logic [1:0] POS_DATA = 2'd2;

	typedef struct packed {
		logic       accept;
		logic       first;
		logic       dec;
		logic       round;
		logic       last;
		logic [3:0] rnd;
		logic       kload;
		logic       kstep;
		logic       kstore;
		logic       finish;
		logic [1:0] kind;
		logic       ok;
		logic       run_end;
	} cmd_t;

	typedef struct packed {
		logic dir;
		logic k0_match;
	} status_t;

	localparam logic [0:255][7:0] SBOX = {
		128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
	};

	localparam logic [0:255][7:0] INV_SBOX = {
		128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
		128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
		128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
		128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
		128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
		128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
		128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
		128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
	};

	function automatic logic [7:0] rcon(input logic [3:0] idx);
		logic [7:0] r;
		unique case (idx)
			4'd0: r = 8'h01;
			4'd1: r = 8'h02;
			4'd2: r = 8'h04;
			4'd3: r = 8'h08;
			4'd4: r = 8'h10;
			4'd5: r = 8'h20;
			4'd6: r = 8'h40;
			4'd7: r = 8'h80;
			4'd8: r = 8'h1b;
			4'd9: r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] transpose(input logic [127:0] w);
		logic [127:0] o;
		for (int i = 0; i < 16; i++) o[8*i +: 8] = w[8*(4*(i%4) + i/4) +: 8];
		return o;
	endfunction

	function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
		logic [127:0] o;
		for (int i = 0; i < 16; i++)
			o[8*i +: 8] = inv ? INV_SBOX[s[8*i +: 8]] : SBOX[s[8*i +: 8]];
		return o;
	endfunction

	function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
		logic [127:0] o;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				o[8*(r + 4*c) +: 8] = inv ? s[8*(r + 4*((c + 4 - r) % 4)) +: 8]
				                          : s[8*(r + 4*((c + r) % 4)) +: 8];
		return o;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s);
		logic [127:0] o;
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = s[8*(4*c) +: 8];
			a1 = s[8*(4*c+1) +: 8];
			a2 = s[8*(4*c+2) +: 8];
			a3 = s[8*(4*c+3) +: 8];
			o[8*(4*c) +: 8]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
			o[8*(4*c+1) +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
			o[8*(4*c+2) +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
			o[8*(4*c+3) +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
		end
		return o;
	endfunction

	function automatic logic [127:0] inv_mix_columns(input logic [127:0] s);
		logic [127:0] o;
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m9 [4];
		logic [7:0] m11 [4];
		logic [7:0] m13 [4];
		logic [7:0] m14 [4];
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				a[k]   = s[8*(4*c+k) +: 8];
				x2[k]  = xtime(a[k]);
				x4[k]  = xtime(x2[k]);
				x8[k]  = xtime(x4[k]);
				m9[k]  = x8[k] ^ a[k];
				m11[k] = x8[k] ^ x2[k] ^ a[k];
				m13[k] = x8[k] ^ x4[k] ^ a[k];
				m14[k] = x8[k] ^ x4[k] ^ x2[k];
			end
			o[8*(4*c) +: 8]   = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
			o[8*(4*c+1) +: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
			o[8*(4*c+2) +: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
			o[8*(4*c+3) +: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
		end
		return o;
	endfunction

	// next round key, untransposed byte order
	function automatic logic [127:0] key_fwd(input logic [127:0] w, input logic [7:0] rc);
		logic [127:0] n;
		logic [31:0] t;
		t = {SBOX[w[12*8 +: 8]], SBOX[w[15*8 +: 8]], SBOX[w[14*8 +: 8]],
		     SBOX[w[13*8 +: 8]] ^ rc};
		n[31:0] = w[31:0] ^ t;
		for (int i = 4; i < 16; i++) n[8*i +: 8] = w[8*i +: 8] ^ n[8*(i-4) +: 8];
		return n;
	endfunction

	// previous round key, untransposed byte order
	function automatic logic [127:0] key_back(input logic [127:0] w, input logic [7:0] rc);
		logic [127:0] n;
		logic [31:0] t;
		for (int i = 4; i < 16; i++) n[8*i +: 8] = w[8*i +: 8] ^ w[8*(i-4) +: 8];
		t = {SBOX[n[12*8 +: 8]], SBOX[n[15*8 +: 8]], SBOX[n[14*8 +: 8]],
		     SBOX[n[13*8 +: 8]] ^ rc};
		n[31:0] = w[31:0] ^ t;
		return n;
	endfunction

endpackage

### src/actk_dp.sv
module actk_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic [63:0]        block_low,
	input  logic [63:0]        block_high,
	input  logic [4:0]         valid_bytes,
	input  actk_pkg::cmd_t     cmd,
	output actk_pkg::status_t  status,
	output logic [63:0]        result_low,
	output logic [63:0]        result_high,
	output logic [1:0]         item_kind,
	output logic               key_ok,
	output logic               run_end
);

	logic [127:0] key_q;
	logic         dir_q;
	logic [127:0] k10_q;
	logic [127:0] rk_q;
	logic [127:0] state_q;
	logic [127:0] block_q;
	logic [127:0] chain_q;
	logic [127:0] res_q;
	logic [1:0]   kind_q;
	logic         ok_q;
	logic         end_q;

	logic [127:0] blk;
	logic [127:0] padded;
	logic [127:0] k0t;
	logic [127:0] knext;
	logic [127:0] kprev;
	logic [127:0] enc_rnd;
	logic [127:0] dec_rnd;
	logic [127:0] result;
	logic [127:0] load_val;

	always_comb begin
		blk = {block_high, block_low};
		for (int i = 0; i < 16; i++)
			padded[8*i +: 8] = (5'(i) < valid_bytes) ? blk[8*i +: 8] : 8'h00;
		k0t   = actk_pkg::transpose(key_q);
		knext = actk_pkg::key_fwd(rk_q, actk_pkg::rcon(cmd.rnd - 4'd1));
		kprev = actk_pkg::key_back(rk_q, actk_pkg::rcon(cmd.rnd));

		enc_rnd = actk_pkg::shift_rows(actk_pkg::sub_bytes(state_q, 1'b0), 1'b0);
		if (!cmd.last) enc_rnd = actk_pkg::mix_columns(enc_rnd);
		enc_rnd = enc_rnd ^ actk_pkg::transpose(knext);

		dec_rnd = actk_pkg::sub_bytes(actk_pkg::shift_rows(state_q, 1'b1), 1'b1)
		        ^ actk_pkg::transpose(kprev);
		if (!cmd.last) dec_rnd = actk_pkg::inv_mix_columns(dec_rnd);

		result = cmd.dec ? (state_q ^ chain_q) : state_q;

		// the echoed iv goes through the initial key add twice
		if (cmd.dec) load_val = blk ^ actk_pkg::transpose(k10_q);
		else if (cmd.first) load_val = blk ^ k0t ^ k0t;
		else load_val = padded ^ chain_q ^ k0t;
	end

	assign status.dir      = dir_q;
	assign status.k0_match = (result == k0t);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			dir_q   <= 1'b0;
			chain_q <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					actk_pkg::REG_KEY_LOW:  key_q[63:0]   <= cfg_data;
					actk_pkg::REG_KEY_HIGH: key_q[127:64] <= cfg_data;
					actk_pkg::REG_DIR:      dir_q         <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.accept && cmd.dec && cmd.first) chain_q <= blk;
			else if (cmd.finish) chain_q <= cmd.dec ? block_q : state_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.kload) rk_q <= key_q;
		else if (cmd.kstep) rk_q <= knext;
		else if (cmd.accept) rk_q <= cmd.dec ? k10_q : key_q;
		else if (cmd.round) rk_q <= cmd.dec ? kprev : knext;
		if (cmd.kstore) k10_q <= knext;
		if (cmd.accept) begin
			state_q <= load_val;
			block_q <= blk;
		end else if (cmd.round) begin
			state_q <= cmd.dec ? dec_rnd : enc_rnd;
		end
		if ((cmd.accept && !cmd.dec && cmd.first) || cmd.finish) begin
			res_q  <= cmd.finish ? result : blk;
			kind_q <= cmd.kind;
			ok_q   <= cmd.ok;
			end_q  <= cmd.run_end;
		end
	end

	assign result_low  = res_q[63:0];
	assign result_high = res_q[127:64];
	assign item_kind   = kind_q;
	assign key_ok      = ok_q;
	assign run_end     = end_q;

endmodule

### src/actk_ctrl.sv
module actk_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               first_block,
	output logic               out_valid,
	input  logic               out_stall,
	input  actk_pkg::status_t  status,
	output actk_pkg::cmd_t     cmd
);

	localparam logic [2:0] S_KLOAD = 3'd0;
	localparam logic [2:0] S_KEYX  = 3'd1;
	localparam logic [2:0] S_IDLE  = 3'd2;
	localparam logic [2:0] S_ROUND = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [3:0] rnd_q;
	logic       out_valid_q;
	logic [1:0] pos_q;
	logic       check_q;
	logic       dec_q;
	logic       first_q;
	logic       held_q;

	logic key_wr;
	logic out_free;
	logic accept;
	logic dec;
	logic round_end;

	assign key_wr   = cfg_write && (cfg_index == actk_pkg::REG_KEY_LOW ||
	                               cfg_index == actk_pkg::REG_KEY_HIGH);
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !(state_q == S_IDLE && out_free && !key_wr);
	assign accept   = in_valid && !in_stall;
	assign dec      = (state_q == S_IDLE) ? status.dir : dec_q;
	assign round_end = dec_q ? (rnd_q == 4'd0) : (rnd_q == actk_pkg::LAST_ROUND);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.accept  = accept;
		cmd.first   = (state_q == S_IDLE) ? first_block : first_q;
		cmd.dec     = dec;
		cmd.rnd     = rnd_q;
		cmd.round   = (state_q == S_ROUND);
		cmd.last    = round_end;
		cmd.kload   = (state_q == S_KLOAD);
		cmd.kstep   = (state_q == S_KEYX);
		cmd.kstore  = (state_q == S_KEYX) && (rnd_q == actk_pkg::LAST_ROUND);
		cmd.finish  = (state_q == S_DONE) && out_free;
		if (state_q == S_IDLE) begin
			cmd.kind    = actk_pkg::KIND_ECHO;
			cmd.run_end = 1'b0;
		end else begin
			cmd.run_end = 1'b1;
			cmd.kind    = (dec_q ? held_q : first_q) ? actk_pkg::KIND_CHECK
			                                         : actk_pkg::KIND_DATA;
			cmd.ok      = dec_q && (check_q || (held_q && status.k0_match));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_KLOAD;
			rnd_q       <= 4'd0;
			out_valid_q <= 1'b0;
			pos_q       <= actk_pkg::POS_IDLE;
			check_q     <= 1'b0;
			dec_q       <= 1'b0;
			first_q     <= 1'b0;
			held_q      <= 1'b0;
		end else begin
			if ((accept && !status.dir && first_block) || cmd.finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;

			if (key_wr) begin
				state_q <= S_KLOAD;
			end else begin
				unique case (state_q)
					S_KLOAD: begin
						rnd_q   <= 4'd1;
						state_q <= S_KEYX;
					end
					S_KEYX: begin
						rnd_q <= rnd_q + 4'd1;
						if (rnd_q == actk_pkg::LAST_ROUND) state_q <= S_IDLE;
					end
					S_IDLE: begin
						if (accept) begin
							dec_q   <= status.dir;
							first_q <= first_block;
							held_q  <= status.dir && !first_block &&
							           pos_q == actk_pkg::POS_IV;
							if (first_block) check_q <= 1'b0;
							pos_q <= (status.dir && first_block) ? actk_pkg::POS_IV
							                                     : actk_pkg::POS_DATA;
							// decrypt iv is only held, no rounds
							if (!(status.dir && first_block)) begin
								rnd_q   <= status.dir ? actk_pkg::LAST_ROUND - 4'd1 : 4'd1;
								state_q <= S_ROUND;
							end
						end
					end
					S_ROUND: begin
						if (round_end) state_q <= S_DONE;
						else rnd_q <= dec_q ? rnd_q - 4'd1 : rnd_q + 4'd1;
					end
					S_DONE: begin
						if (out_free) begin
							state_q <= S_IDLE;
							if (dec_q && held_q && status.k0_match) check_q <= 1'b1;
						end
					end
					default: state_q <= S_KLOAD;
				endcase
			end
		end
	end

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ROUND |-> rnd_q <= actk_pkg::LAST_ROUND)
		else $error("round counter out of range");

	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished block not presented");

	a_keyx_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_KEYX && rnd_q == actk_pkg::LAST_ROUND && !key_wr) |=> state_q == S_IDLE)
		else $error("key expansion did not complete");

	a_pos_code: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != 2'd3)
		else $error("bad message position");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (state_q == S_IDLE && out_free))
		else $error("block taken while busy");

endmodule

### src/aes128_cbc_transposed_keys_unit.sv
// channel   direction  handshake            payload
// in        to unit    in_valid/in_stall    block_low, block_high, first_block, valid_bytes
// out       from unit  out_valid/out_stall  result_low, result_high, item_kind, key_ok, run_end
// cfg       to unit    cfg_write            cfg_index, cfg_data
//
// a data block is loaded, runs through the shared round unit, then hands the result to
// the output register; a decrypt iv is only loaded and held, with no rounds
// an encrypt iv beat is echoed at once, its cipher block follows after the rounds
// after reset and after each key write the last round key is expanded,
// during which in_stall is high
// in_stall is also high while the output register is full and stalled
module aes128_cbc_transposed_keys_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] block_low,
	input  logic [63:0] block_high,
	input  logic        first_block,
	input  logic [4:0]  valid_bytes,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_low,
	output logic [63:0] result_high,
	output logic [1:0]  item_kind,
	output logic        key_ok,
	output logic        run_end
);

	actk_pkg::cmd_t    cmd;
	actk_pkg::status_t status;

	actk_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.first_block (first_block),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.cmd         (cmd)
	);

	actk_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.block_low   (block_low),
		.block_high  (block_high),
		.valid_bytes (valid_bytes),
		.cmd         (cmd),
		.status      (status),
		.result_low  (result_low),
		.result_high (result_high),
		.item_kind   (item_kind),
		.key_ok      (key_ok),
		.run_end     (run_end)
	);

endmodule
